FILE: src/aes128_pkg.sv
// ----------------------------------------------------------------------------
// aes128_pkg
// Shared types, constants and round functions for the AES-128 encrypt core.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [7:0]         byte_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  // round constants, one per round stage
  localparam byte_t RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // forward s-box: field inverse followed by the affine map
  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // byte i of a block, byte 0 in the top bits
  function automatic byte_t get_byte(block_t s, int unsigned i);
    return s[BLOCK_W-1-8*i -: 8];
  endfunction

  // multiply by x in GF(2^8)
  function automatic byte_t xtime(byte_t a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  // s-box on every byte
  function automatic block_t sub_bytes(block_t s);
    block_t t;
    for (int unsigned i = 0; i < 16; i++) begin
      t[BLOCK_W-1-8*i -: 8] = SBOX[get_byte(s, i)];
    end
    return t;
  endfunction

  // row r rotates left by r columns
  function automatic block_t shift_rows(block_t s);
    block_t t;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(4*c+r) -: 8] = get_byte(s, 4*((c+r)%4)+r);
      end
    end
    return t;
  endfunction

  // column mix, each column on its own
  function automatic block_t mix_columns(block_t s);
    block_t t;
    byte_t  a0, a1, a2, a3, all;
    for (int unsigned c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c+1);
      a2  = get_byte(s, 4*c+2);
      a3  = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // one step of the key schedule
  function automatic block_t next_key(block_t k, byte_t rc);
    byte_t  w [16];
    block_t t;
    for (int unsigned i = 0; i < 16; i++) begin
      w[i] = get_byte(k, i);
    end
    w[0] = w[0] ^ SBOX[w[13]] ^ rc;
    w[1] = w[1] ^ SBOX[w[14]];
    w[2] = w[2] ^ SBOX[w[15]];
    w[3] = w[3] ^ SBOX[w[12]];
    for (int unsigned i = 4; i < 16; i++) begin
      w[i] = w[i] ^ w[i-4];
    end
    for (int unsigned i = 0; i < 16; i++) begin
      t[BLOCK_W-1-8*i -: 8] = w[i];
    end
    return t;
  endfunction

endpackage

FILE: src/aes128_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core
// AES-128 block encryption, one round cell per round in a chain.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through cfg_we_i / cfg_idx_i / cfg_data_i: index 0 holds
//   key bytes 0..7, index 1 key bytes 8..15. Write it only while the core is
//   empty. A plaintext beat is taken on plain_valid_i && !plain_stall_o; the
//   ciphertext beat leaves on cipher_valid_o && !cipher_stall_i.
//   The initial key addition happens at the input; then ten round cells each
//   run one round and expand their own round key. Every cell is a register
//   stage, so an accepted beat passes through all ten cell registers on its way to
//   cipher_valid_o. Throughput is one block per cycle while cipher_stall_i is low,
//   set by the single round of logic between cell registers.
//   When the receiver stalls, the last cell holds its result; earlier cells
//   keep filling empty slots behind it, and plain_stall_o rises only once
//   every cell holds a block.
//   Reset empties all cells and clears both key registers to zero.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  aes128_pkg::half_t                     cfg_data_i,
  input  logic                                  plain_valid_i,
  output logic                                  plain_stall_o,
  input  aes128_pkg::half_t                     plain_high_i,
  input  aes128_pkg::half_t                     plain_low_i,
  output logic                                  cipher_valid_o,
  input  logic                                  cipher_stall_i,
  output aes128_pkg::half_t                     cipher_high_o,
  output aes128_pkg::half_t                     cipher_low_o
);

  localparam int unsigned NR = aes128_pkg::NUM_ROUNDS;

  aes128_pkg::half_t  key_high_q, key_low_q;
  logic               valid [NR+1];
  logic               ready [NR+1];
  aes128_pkg::block_t state [NR+1];
  aes128_pkg::block_t rkey  [NR+1];

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes128_pkg::REG_KEY_HIGH: key_high_q <= cfg_data_i;
        aes128_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // initial key addition at the head of the chain
  assign valid[0]      = plain_valid_i;
  assign rkey[0]       = {key_high_q, key_low_q};
  assign state[0]      = {plain_high_i, plain_low_i} ^ rkey[0];
  assign plain_stall_o = !ready[0];

  // chain of round cells
  for (genvar g = 0; g < NR; g++) begin : g_round
    aes128_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .rcon_i  (aes128_pkg::RCON[g]),
      .last_i  (g == NR - 1),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .state_i (state[g]),
      .key_i   (rkey[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .state_o (state[g+1]),
      .key_o   (rkey[g+1])
    );
  end

  // output beat from the last cell
  assign ready[NR]      = !cipher_stall_i;
  assign cipher_valid_o = valid[NR];
  assign cipher_high_o  = state[NR][aes128_pkg::BLOCK_W-1 -: aes128_pkg::HALF_W];
  assign cipher_low_o   = state[NR][aes128_pkg::HALF_W-1:0];

endmodule

FILE: src/aes128_round_cell.sv
// ----------------------------------------------------------------------------
// aes128_round_cell
// One cipher round with its key schedule step, registered at the output.
// ----------------------------------------------------------------------------
module aes128_round_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aes128_pkg::byte_t      rcon_i,
  input  logic                   last_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  aes128_pkg::block_t     state_i,
  input  aes128_pkg::block_t     key_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output aes128_pkg::block_t     state_o,
  output aes128_pkg::block_t     key_o
);

  logic               valid_q;
  aes128_pkg::block_t state_q, state_d;
  aes128_pkg::block_t key_q, key_d;
  aes128_pkg::block_t shifted;

  // cell takes a beat when empty or when its contents move on
  assign ready_o = !valid_q || ready_i;

  // round datapath
  always_comb begin
    shifted = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(state_i));
    key_d   = aes128_pkg::next_key(key_i, rcon_i);
    if (last_i) begin
      state_d = shifted ^ key_d;
    end else begin
      state_d = aes128_pkg::mix_columns(shifted) ^ key_d;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule
